// ===== src/csi_pkg.sv =====
`default_nettype none

package csi_pkg;

    // Width of the two accumulated numbers; both saturate at all ones.
    localparam int NUM_W = 16;

    // Width of one result item on the wire, padded up to whole bytes.
    localparam int RES_BITS  = 4 + 8 + 16 + 16 + 1 + 32;
    localparam int RES_BYTES = (RES_BITS + 7) / 8;
    localparam int OUT_W     = RES_BYTES * 8;

    // Character codes the parser reacts to.
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_BRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_GOTO_H  = 8'h48;
    localparam logic [7:0] CH_GOTO_F  = 8'h66;
    localparam logic [7:0] CH_UP      = 8'h41;
    localparam logic [7:0] CH_DOWN    = 8'h42;
    localparam logic [7:0] CH_RIGHT   = 8'h43;
    localparam logic [7:0] CH_LEFT    = 8'h44;
    localparam logic [7:0] CH_SAVE    = 8'h73;
    localparam logic [7:0] CH_RESTORE = 8'h75;
    localparam logic [7:0] CH_COLOR   = 8'h6D;

    // Color word pieces.
    localparam logic [31:0] COLOR_ALPHA = 32'hFF00_0000;
    localparam logic [31:0] COLOR_RED   = 32'h00FF_0000;
    localparam logic [31:0] COLOR_GREEN = 32'h0000_FF00;
    localparam logic [31:0] COLOR_BLUE  = 32'h0000_00FF;

    typedef enum logic [3:0] {
        CMD_PRINT   = 4'd0,
        CMD_GOTO    = 4'd1,
        CMD_UP      = 4'd2,
        CMD_DOWN    = 4'd3,
        CMD_RIGHT   = 4'd4,
        CMD_LEFT    = 4'd5,
        CMD_SAVE    = 4'd6,
        CMD_RESTORE = 4'd7,
        CMD_COLOR   = 4'd8
    } t_cmd;

    typedef struct packed {
        logic        last;
        logic [31:0] color_word;
        logic        to_foreground;
        logic [15:0] second_value;
        logic [15:0] first_value;
        logic [7:0]  char_code;
        t_cmd        command;
    } t_result;

    typedef struct packed {
        logic    vld;
        t_result res;
    } t_push;

endpackage

`default_nettype wire

// ===== src/csi_decode.sv =====
`default_nettype none

module csi_decode
    import csi_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_byte_vld,
    input  wire logic [7:0] i_byte,
    output logic            o_byte_rdy,
    input  wire logic       i_room,
    output t_push           o_push
);

    localparam int ACC_W = NUM_W + 4;
    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};
    // Units digit of the saturated value, worked out at elaboration.
    localparam logic [3:0] SAT_UNITS = 4'(((64'd1 << NUM_W) - 64'd1) % 64'd10);

    // Input register.
    logic       r_in_vld;
    logic [7:0] r_byte;

    // Parser state. The units digit of each number is tracked alongside it,
    // since the last digit shifted in is the value modulo ten.
    logic             r_in_seq, n_in_seq;
    logic             r_await, n_await;
    logic             r_second, n_second;
    logic             r_nodig, n_nodig;
    logic [NUM_W-1:0] r_num1, n_num1;
    logic [NUM_W-1:0] r_num2, n_num2;
    logic [3:0]       r_units1, n_units1;
    logic [3:0]       r_units2, n_units2;

    // Second color write of a two-number m sequence waits here until there is room.
    logic    r_pend_vld;
    t_result r_pend;

    logic    produces;
    logic    two;
    logic    take;
    t_result res;
    t_result res2;
    logic [15:0] count;

    function automatic logic [NUM_W+3:0] acc_wide(input logic [NUM_W-1:0] n,
                                                 input logic [3:0] d);
        logic [NUM_W+3:0] w;
        begin
            w = ((NUM_W+4)'(n) << 3) + ((NUM_W+4)'(n) << 1) + (NUM_W+4)'(d);
            return w;
        end
    endfunction

    function automatic t_result color_res(input logic [NUM_W-1:0] n,
                                          input logic [3:0] units,
                                          input logic is_last);
        t_result r;
        begin
            r               = '0;
            r.command       = CMD_COLOR;
            r.to_foreground = (n >= NUM_W'(30)) && (n <= NUM_W'(39));
            r.color_word    = COLOR_ALPHA
                            | (units[0] ? COLOR_RED   : 32'h0)
                            | (units[1] ? COLOR_GREEN : 32'h0)
                            | (units[2] ? COLOR_BLUE  : 32'h0);
            r.last          = is_last;
            return r;
        end
    endfunction

    logic [ACC_W-1:0] wide1;
    logic [ACC_W-1:0] wide2;

    assign wide1 = acc_wide(r_num1, r_byte[3:0]);
    assign wide2 = acc_wide(r_num2, r_byte[3:0]);
    assign count = r_nodig ? 16'd1 : 16'(r_num1);

    always_comb begin
        n_in_seq = r_in_seq;
        n_await  = r_await;
        n_second = r_second;
        n_nodig  = r_nodig;
        n_num1   = r_num1;
        n_num2   = r_num2;
        n_units1 = r_units1;
        n_units2 = r_units2;
        produces = 1'b0;
        two      = 1'b0;
        res      = '0;
        res.last = 1'b1;
        res2     = '0;

        if (r_byte == CH_NUL) begin
            // Ignored everywhere.
        end else if (r_byte == CH_ESC) begin
            n_in_seq = 1'b1;
            n_await  = 1'b1;
            n_second = 1'b0;
            n_nodig  = 1'b1;
            n_num1   = '0;
            n_num2   = '0;
            n_units1 = '0;
            n_units2 = '0;
        end else if (!r_in_seq) begin
            produces      = 1'b1;
            res.command   = CMD_PRINT;
            res.char_code = r_byte;
        end else if (r_await) begin
            if (r_byte == CH_BRACKET) begin
                n_await = 1'b0;
            end
        end else if (r_byte >= CH_ZERO && r_byte <= CH_NINE) begin
            n_nodig = 1'b0;
            if (r_second) begin
                if (wide2[ACC_W-1:NUM_W] != '0) begin
                    n_num2   = NUM_MAX;
                    n_units2 = SAT_UNITS;
                end else begin
                    n_num2   = wide2[NUM_W-1:0];
                    n_units2 = r_byte[3:0];
                end
            end else begin
                if (wide1[ACC_W-1:NUM_W] != '0) begin
                    n_num1   = NUM_MAX;
                    n_units1 = SAT_UNITS;
                end else begin
                    n_num1   = wide1[NUM_W-1:0];
                    n_units1 = r_byte[3:0];
                end
            end
        end else if (r_byte == CH_SEMI) begin
            n_second = 1'b1;
        end else begin
            n_in_seq = 1'b0;
            case (r_byte)
                CH_GOTO_H, CH_GOTO_F: begin
                    produces         = 1'b1;
                    res.command      = CMD_GOTO;
                    res.first_value  = 16'(r_num1);
                    res.second_value = 16'(r_num2);
                end
                CH_UP: begin
                    produces        = 1'b1;
                    res.command     = CMD_UP;
                    res.first_value = count;
                end
                CH_DOWN: begin
                    produces        = 1'b1;
                    res.command     = CMD_DOWN;
                    res.first_value = count;
                end
                CH_RIGHT: begin
                    produces        = 1'b1;
                    res.command     = CMD_RIGHT;
                    res.first_value = count;
                end
                CH_LEFT: begin
                    produces        = 1'b1;
                    res.command     = CMD_LEFT;
                    res.first_value = count;
                end
                CH_SAVE: begin
                    produces    = 1'b1;
                    res.command = CMD_SAVE;
                end
                CH_RESTORE: begin
                    produces    = 1'b1;
                    res.command = CMD_RESTORE;
                end
                CH_COLOR: begin
                    produces = 1'b1;
                    two      = r_second;
                    res      = color_res(r_num1, r_units1, !r_second);
                    res2     = color_res(r_num2, r_units2, 1'b1);
                end
                default: begin
                    // Unknown final: the sequence closes with no command.
                end
            endcase
        end
    end

    assign take       = r_in_vld && !r_pend_vld && (!produces || i_room);
    assign o_byte_rdy = !r_in_vld || take;

    always_comb begin
        o_push = '0;
        if (r_pend_vld) begin
            o_push.vld = i_room;
            o_push.res = r_pend;
        end else begin
            o_push.vld = take && produces;
            o_push.res = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_in_seq   <= 1'b0;
            r_await    <= 1'b0;
            r_second   <= 1'b0;
            r_nodig    <= 1'b1;
            r_num1     <= '0;
            r_num2     <= '0;
            r_units1   <= '0;
            r_units2   <= '0;
        end else begin
            if (o_byte_rdy) begin
                r_in_vld <= i_byte_vld;
            end
            if (r_pend_vld && i_room) begin
                r_pend_vld <= 1'b0;
            end else if (take && produces && two) begin
                r_pend_vld <= 1'b1;
            end
            if (take) begin
                r_in_seq <= n_in_seq;
                r_await  <= n_await;
                r_second <= n_second;
                r_nodig  <= n_nodig;
                r_num1   <= n_num1;
                r_num2   <= n_num2;
                r_units1 <= n_units1;
                r_units2 <= n_units2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_byte_rdy && i_byte_vld) begin
            r_byte <= i_byte;
        end
        if (take && two) begin
            r_pend <= res2;
        end
    end

    // A held second color write only exists right after an m final.
    a_pend_out_of_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> !r_in_seq)
        else $error("pending color write while a sequence is open");

    a_pend_is_last_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (r_pend.command == CMD_COLOR) && r_pend.last)
        else $error("pending result is not the closing color write");

    a_bracket_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> r_in_seq)
        else $error("waiting for bracket outside a sequence");

    a_nodig_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nodig |-> (r_num1 == '0) && (r_num2 == '0))
        else $error("numbers nonzero before any digit");

endmodule

`default_nettype wire

// ===== src/csi_out_fifo.sv =====
`default_nettype none

module csi_out_fifo
    import csi_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_push   i_push,
    output logic         o_room,
    output logic         o_vld,
    output t_result      o_res,
    input  wire logic    i_pop_rdy
);

    // Two entries: one can drain while the next is written, so a full
    // beat rate holds with the room flag taken straight from the count.
    t_result    r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       pop;

    assign o_room = (r_count != 2'd2);
    assign o_vld  = (r_count != 2'd0);
    assign o_res  = r_mem[r_rd];
    assign pop    = o_vld && i_pop_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push.vld) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            case ({i_push.vld, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_mem[r_wr] <= i_push.res;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.vld |-> (r_count != 2'd2))
        else $error("write into a full result buffer");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result buffer count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count == 2'd0) || (r_count == 2'd2)) |-> (r_wr == r_rd))
        else $error("buffer pointers disagree with count");

endmodule

`default_nettype wire

// ===== src/ansi_escape_sequence_parser.sv =====
// Channel   Dir  Bits  tdata fields (lsb first)                          Side band
// --------  ---  ----  ------------------------------------------------  ---------------
// s_axis    in   8     byte_in[7:0]                                      none
// m_axis    out  80    command[3:0] char_code[11:4] first_value[27:12]   tlast = last
//                      second_value[43:28] to_foreground[44]
//                      color_word[76:45], zeros[79:77]
//
// One input byte is taken every cycle unless a second color write is held or
// a result is due with no buffer room. A byte is registered in the input
// register, where the parser state is applied, and its result is written into
// the result buffer that drives m_axis. An m final with two numbers produces
// two color writes; the second is held in the decoder until the buffer has room.
// A two-entry result buffer sits between decoder and m_axis; s_axis_tready has
// no combinational path from m_axis_tready, but input stalls while a result is
// due and both buffer entries are still waiting for the receiver.
// Reset is synchronous and active low; it clears the parser state and empties
// both the input register and the result buffer.
`default_nettype none

module ansi_escape_sequence_parser
    import csi_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,

    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata,   // byte_in[7:0]

    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // command, char_code, first_value,
                                                  // second_value, to_foreground,
                                                  // color_word, zero pad
    output logic                  m_axis_tlast
);

    t_push   push;
    logic    room;
    t_result res;

    // The decoder owns the input register and all escape-sequence state.
    csi_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (s_axis_tvalid),
        .i_byte     (s_axis_tdata),
        .o_byte_rdy (s_axis_tready),
        .i_room     (room),
        .o_push     (push)
    );

    // Results are registered here before leaving the block.
    csi_out_fifo u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_room    (room),
        .o_vld     (m_axis_tvalid),
        .o_res     (res),
        .i_pop_rdy (m_axis_tready)
    );

    // Pack every field except last into tdata, lowest field first.
    assign m_axis_tdata = {(OUT_W - RES_BITS)'(0), res.color_word, res.to_foreground,
                           res.second_value, res.first_value, res.char_code,
                           4'(res.command)};
    assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import csi_pkg::*;

    // Cycles with no beat on either side before the run is declared hung.
    // The long receiver hold-off below is far shorter than this.
    localparam int unsigned HANG_LIMIT = 3000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int RANDOM_PER_PHASE = 480;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = 8'h00;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tlast;

    ansi_escape_sequence_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Percent of cycles in which each side idles; changed between phases.
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    // Remaining cycles of a forced receiver hold-off.
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int errors = 0;

    // Commands the parser owes us, oldest first.
    t_result pending_cmds[$];

    // Shadow of the parser state, updated as each byte is accepted.
    logic        in_esc = 1'b0;
    logic        want_bracket = 1'b0;
    logic        on_second = 1'b0;
    logic        no_digit = 1'b1;
    logic [15:0] num_a = '0;
    logic [15:0] num_b = '0;

    // ------------------------------------------------------------------
    // Command predictor
    // ------------------------------------------------------------------

    // Appends one decimal digit; the number sticks at all ones once it
    // would overflow.
    function automatic logic [15:0] add_digit(logic [15:0] n, logic [7:0] ch);
        logic [31:0] v;
        v = 32'(n) * 32'd10 + 32'(ch - CH_ZERO);
        return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    task automatic owe_cmd(input t_cmd cmd, input logic [7:0] ch, input logic [15:0] v1,
                           input logic [15:0] v2, input logic fg, input logic [31:0] color,
                           input logic is_last);
        t_result r;
        r.command       = cmd;
        r.char_code     = ch;
        r.first_value   = v1;
        r.second_value  = v2;
        r.to_foreground = fg;
        r.color_word    = color;
        r.last          = is_last;
        pending_cmds.push_back(r);
    endtask

    // A color number: tens of exactly 3 selects the foreground, and the low
    // three bits of the units digit switch red, green and blue fully on.
    task automatic owe_color(input logic [15:0] n, input logic is_last);
        logic [15:0] units;
        logic [31:0] color;
        units = n % 16'd10;
        color = COLOR_ALPHA;
        if (units[0]) color = color + COLOR_RED;
        if (units[1]) color = color + COLOR_GREEN;
        if (units[2]) color = color + COLOR_BLUE;
        owe_cmd(CMD_COLOR, 8'h00, 16'h0, 16'h0, (n / 16'd10) == 16'd3, color, is_last);
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [15:0] count;
        if (b == CH_NUL)
            return;
        if (b == CH_ESC) begin
            // ESC always opens a fresh sequence, even inside one.
            in_esc       = 1'b1;
            want_bracket = 1'b1;
            on_second    = 1'b0;
            no_digit     = 1'b1;
            num_a        = '0;
            num_b        = '0;
            return;
        end
        if (!in_esc) begin
            owe_cmd(CMD_PRINT, b, 16'h0, 16'h0, 1'b0, 32'h0, 1'b1);
            return;
        end
        if (want_bracket) begin
            if (b == CH_BRACKET)
                want_bracket = 1'b0;
            return;
        end
        if (b >= CH_ZERO && b <= CH_NINE) begin
            if (on_second)
                num_b = add_digit(num_b, b);
            else
                num_a = add_digit(num_a, b);
            no_digit = 1'b0;
            return;
        end
        if (b == CH_SEMI) begin
            on_second = 1'b1;
            return;
        end
        // Any other byte is a final and closes the sequence. A digit seen
        // only after ';' still clears the default count of one.
        in_esc = 1'b0;
        count = no_digit ? 16'd1 : num_a;
        case (b)
            CH_GOTO_H, CH_GOTO_F: owe_cmd(CMD_GOTO, 8'h00, num_a, num_b, 1'b0, 32'h0, 1'b1);
            CH_UP:      owe_cmd(CMD_UP, 8'h00, count, 16'h0, 1'b0, 32'h0, 1'b1);
            CH_DOWN:    owe_cmd(CMD_DOWN, 8'h00, count, 16'h0, 1'b0, 32'h0, 1'b1);
            CH_RIGHT:   owe_cmd(CMD_RIGHT, 8'h00, count, 16'h0, 1'b0, 32'h0, 1'b1);
            CH_LEFT:    owe_cmd(CMD_LEFT, 8'h00, count, 16'h0, 1'b0, 32'h0, 1'b1);
            CH_SAVE:    owe_cmd(CMD_SAVE, 8'h00, 16'h0, 16'h0, 1'b0, 32'h0, 1'b1);
            CH_RESTORE: owe_cmd(CMD_RESTORE, 8'h00, 16'h0, 16'h0, 1'b0, 32'h0, 1'b1);
            CH_COLOR: begin
                // With a ';' present there are two writes, and only the
                // second one carries tlast.
                if (on_second) begin
                    owe_color(num_a, 1'b0);
                    owe_color(num_b, 1'b1);
                end else begin
                    owe_color(num_a, 1'b1);
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Byte sender
    // ------------------------------------------------------------------

    // Offers one byte and returns at the edge where it is taken. Valid stays
    // high afterwards, so back-to-back bytes follow without a gap; it drops
    // only for a random idle cycle or a pause.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(255));
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        parse_byte(b);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i]);
    endtask

    // Stops offering and waits for every owed command, then for the settle
    // period in case a byte without a result is still in flight.
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver side and result checking
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
        end
    endtask

    t_result owed;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_cmds.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected, actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
            end else begin
                owed = pending_cmds.pop_front();
                // tdata from bit 0 up: command, char_code, first_value,
                // second_value, to_foreground, color_word; last is tlast.
                check_field("command", 32'(owed.command), 32'(m_axis_tdata[3:0]));
                check_field("char_code", 32'(owed.char_code), 32'(m_axis_tdata[11:4]));
                check_field("first_value", 32'(owed.first_value), 32'(m_axis_tdata[27:12]));
                check_field("second_value", 32'(owed.second_value),
                            32'(m_axis_tdata[43:28]));
                check_field("to_foreground", 32'(owed.to_foreground), 32'(m_axis_tdata[44]));
                check_field("color_word", owed.color_word, m_axis_tdata[76:45]);
                check_field("last", 32'(owed.last), 32'(m_axis_tlast));
            end
        end
    end

    // Hang detection: a long run of cycles with no beat on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Plain bytes: NUL is dropped, everything else prints as is.
    task automatic test_plain_bytes();
        send_byte(CH_NUL);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h7F);
    endtask

    // Goto with and without numbers, moves with explicit, default and
    // saturated counts, a count given only after ';', save and restore.
    task automatic test_cursor_commands();
        send_text("\033[12;34H");
        send_text("\033[f");
        send_text("\033[A");
        send_text("\033[7B");
        send_text("\033[;5C");
        send_text("\033[99999D");
        send_text("\033[s\033[u");
    endtask

    // One color write, two color writes, a bare m, and a number whose tens
    // quotient is not 3 despite starting with 3.
    task automatic test_color_writes();
        send_text("\033[31m");
        send_text("\033[47;30m");
        send_text("\033[m");
        send_text("\033[399;65535m");
    endtask

    // ESC restarting a sequence, bytes dropped before the bracket, NUL in a
    // sequence, an unknown final, and an overflowing second number.
    task automatic test_sequence_corners();
        send_text("\033x\0334[\0332;\033[5A");
        send_text("\033[1");
        send_byte(CH_NUL);
        send_text("2H");
        send_text("\033[5z");
        send_text("\033[1;999999;H");
    endtask

    // Receiver stops for a long stretch while a burst of bytes keeps coming,
    // so the parser's buffers fill and it must stall its input.
    task automatic test_output_backpressure();
        hold_left <= HOLD_OFF_CYCLES;
        for (int i = 0; i < 20; i++)
            send_byte(8'($urandom_range(1, 255)) | 8'h80);
        send_text("\033[32;46m\033[44;33m\033[3;4H");
        pause_until_drained();
    endtask

    task automatic send_number();
        string txt;
        int kind;
        kind = $urandom_range(5);
        case (kind)
            0: txt = "";
            1: txt = $sformatf("%0d", $urandom_range(9));
            2: txt = $sformatf("%0d", $urandom_range(30, 49));
            3: txt = $sformatf("%0d", $urandom_range(999));
            4: txt = $sformatf("%0d", $urandom_range(70000));
            default: begin
                txt = "";
                repeat ($urandom_range(6, 10))
                    txt = {txt, $sformatf("%0d", $urandom_range(9))};
            end
        endcase
        if (kind != 0 && $urandom_range(9) == 0)
            txt = {"0", txt};
        send_text(txt);
    endtask

    // Mostly well-formed sequences with random content; some have stray
    // bytes before the bracket or unknown finals.
    task automatic send_random_sequence();
        logic [7:0] finals[11] = '{CH_GOTO_H, CH_GOTO_F, CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT,
                                   CH_SAVE, CH_RESTORE, CH_COLOR, CH_COLOR, CH_COLOR};
        logic [7:0] b;
        send_byte(CH_ESC);
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                do
                    b = 8'($urandom_range(255));
                while (b == CH_ESC || b == CH_BRACKET);
                send_byte(b);
            end
        end
        send_byte(CH_BRACKET);
        if ($urandom_range(29) == 0)
            send_byte(CH_NUL);
        send_number();
        if ($urandom_range(2) == 0) begin
            send_byte(CH_SEMI);
            send_number();
        end
        if ($urandom_range(9) == 0)
            b = 8'($urandom_range(1, 255));
        else
            b = finals[$urandom_range(10)];
        send_byte(b);
    endtask

    task automatic test_random_stream(input int n_bytes);
        int start;
        start = 0;
        while (start < n_bytes) begin
            if ($urandom_range(99) < 25) begin
                repeat ($urandom_range(1, 6)) begin
                    send_byte(8'($urandom_range(255)));
                    start++;
                end
            end else begin
                send_random_sequence();
                start += 8;
            end
        end
        pause_until_drained();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase one: sender idles a quarter of the time, receiver about half.
        src_idle_pct  = 25;
        sink_idle_pct = 53;
        test_plain_bytes();
        test_cursor_commands();
        test_color_writes();
        test_sequence_corners();
        pause_until_drained();
        test_output_backpressure();
        test_random_stream(RANDOM_PER_PHASE);

        // Phase two: the idle rates swap sides.
        src_idle_pct  = 53;
        sink_idle_pct = 25;
        test_random_stream(RANDOM_PER_PHASE);

        // Phase three: full rate on both sides.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_stream(RANDOM_PER_PHASE);

        if (pending_cmds.size() != 0)
            errors++;
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/csi_pkg.sv
src/csi_decode.sv
src/csi_out_fifo.sv
src/ansi_escape_sequence_parser.sv
tb/sv/tb_top.sv
